### design/optimal_pla_segmenter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PLA segmenter
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef OPTIMAL_PLA_SEGMENTER_UNIT_MACROS_SVH
`define OPTIMAL_PLA_SEGMENTER_UNIT_MACROS_SVH

// same-cycle implication
`define OPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/opseg_pkg.sv
// ----------------------------------------------------------------------------
// opseg_pkg
// Types, constants and saturation helpers of the PLA segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package opseg_pkg;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
    localparam logic [30:0] ERR_BOUND_RESET = 31'd65536;

    // support chain operation
    typedef enum logic [1:0] {
        CH_HOLD,
        CH_SHIFT,
        CH_ROTATE,
        CH_LOAD
    } chain_op_t;

    // multiplier phases
    typedef enum logic [1:0] {
        MP_IDLE,
        MP_HIGH,
        MP_LOW,
        MP_JOIN
    } mul_phase_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_DIV,
        ST_INIT_DIVW,
        ST_INIT_MUL,
        ST_INIT_MULW,
        ST_EVAL_MUL,
        ST_EVAL_MULW,
        ST_DECIDE,
        ST_SCAN_DIV,
        ST_SCAN_DIVW,
        ST_SCAN_MUL,
        ST_SCAN_MULW,
        ST_CHECK,
        ST_DROP,
        ST_APPEND,
        ST_EMIT
    } state_t;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
        logic signed [47:0] r;
        if (x > 49'(MAX48))      r = MAX48;
        else if (x < 49'(MIN48)) r = MIN48;
        else                     r = x[47:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
        else if (x < -34'sh0_8000_0000) r = 32'sh8000_0000;
        else                            r = x[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### design/opseg_cell.sv
// ----------------------------------------------------------------------------
// opseg_cell
// One support point slot of a chain: hold, shift, rotate or load.
// ----------------------------------------------------------------------------
`default_nettype none

module opseg_cell
    import opseg_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter logic [IDX_W-1:0] MY_IDX = '0
) (
    input  wire logic             aclk,
    input  wire chain_op_t        op,
    input  wire logic [IDX_W-1:0] sel,
    input  wire logic [63:0]      din,
    input  wire logic [63:0]      right,
    input  wire logic [63:0]      head_in,
    output logic [63:0]           q
);

    logic [63:0] point_reg;
    logic [63:0] point_next;

    // next point: take neighbor, wrap the head at the last used slot, or load
    always_comb begin
        point_next = point_reg;
        case (op)
            CH_SHIFT:  point_next = right;
            CH_ROTATE: point_next = (sel == MY_IDX) ? head_in : right;
            CH_LOAD:   if (sel == MY_IDX) point_next = din;
            default:   point_next = point_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        point_reg <= point_next;
    end

    assign q = point_reg;

endmodule

`default_nettype wire

### design/opseg_chain.sv
// ----------------------------------------------------------------------------
// opseg_chain
// Row of support point cells; slot 0 is the head seen by the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module opseg_chain
    import opseg_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic             aclk,
    input  wire chain_op_t        op,
    input  wire logic [IDX_W-1:0] sel,
    input  wire logic [63:0]      din,
    output logic [63:0]           head
);

    logic [63:0] pts [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [63:0] nbr;
            if (gi == DEPTH - 1) begin : g_end
                assign nbr = '0;
            end else begin : g_mid
                assign nbr = pts[gi+1];
            end
            opseg_cell #(
                .IDX_W  (IDX_W),
                .MY_IDX (IDX_W'(gi))
            ) u_cell (
                .aclk    (aclk),
                .op      (op),
                .sel     (sel),
                .din     (din),
                .right   (nbr),
                .head_in (pts[0]),
                .q       (pts[gi])
            );
        end
    endgenerate

    assign head = pts[0];

endmodule

`default_nettype wire

### design/opseg_div.sv
// ----------------------------------------------------------------------------
// opseg_div
// Slope divider: (dy * 65536) / dt, truncated toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module opseg_div
    import opseg_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [32:0] dy,
    input  wire logic [31:0]        dt,
    output logic                    done,
    output logic signed [47:0]      quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  step_reg, step_next;
    logic [48:0] nq_reg, nq_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dt_reg, dt_next;
    logic        neg_reg, neg_next;

    logic [32:0] mag;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;
    logic [48:0] nq_neg;

    assign mag     = dy[32] ? 33'(-dy) : 33'(dy);
    assign rem_sh  = {rem_reg, nq_reg[48]};
    assign ge      = rem_sh >= {1'b0, dt_reg};
    assign rem_sub = rem_sh - {1'b0, dt_reg};

    // restoring division step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        dt_next   = dt_reg;
        neg_next  = neg_reg;
        if (start) begin
            neg_next = dy[32];
            dt_next  = dt;
            rem_next = '0;
            step_next = 6'd48;
            if (dt == '0) begin
                nq_next   = '0;
                done_next = 1'b1;
            end else begin
                nq_next   = {mag, 16'b0};
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[31:0] : rem_sh[31:0];
            nq_next  = {nq_reg[47:0], ge};
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        nq_reg   <= nq_next;
        rem_reg  <= rem_next;
        dt_reg   <= dt_next;
        neg_reg  <= neg_next;
    end

    // sign and saturate the magnitude quotient
    assign nq_neg = -nq_reg;
    always_comb begin
        if (neg_reg) begin
            quot = (nq_reg > 49'h0_8000_0000_0000) ? MIN48 : nq_neg[47:0];
        end else begin
            quot = (nq_reg > 49'(MAX48)) ? MAX48 : nq_reg[47:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

### design/opseg_mul.sv
// ----------------------------------------------------------------------------
// opseg_mul
// Saturating slope by time product: 48-bit signed times 32-bit unsigned,
// done as two 48x16 partial products on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module opseg_mul
    import opseg_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [47:0] a,
    input  wire logic [31:0]        x,
    output logic                    done,
    output logic signed [47:0]      prod
);

    mul_phase_t  phase_reg, phase_next;
    logic        done_reg;
    logic [47:0] mag_reg;
    logic        neg_reg;
    logic [31:0] x_reg;
    logic [63:0] p_reg;
    logic [63:0] ph_reg;
    logic signed [47:0] res_reg;

    logic [15:0] mop;
    logic [63:0] pmul;
    logic [64:0] tot_raw;
    logic [47:0] tot;
    logic [48:0] tot_neg;
    logic signed [47:0] res_calc;

    always_comb begin
        case (phase_reg)
            MP_IDLE: phase_next = start ? MP_HIGH : MP_IDLE;
            MP_HIGH: phase_next = MP_LOW;
            MP_LOW:  phase_next = MP_JOIN;
            MP_JOIN: phase_next = MP_IDLE;
            default: phase_next = MP_IDLE;
        endcase
    end

    // shared multiplier: high half of x first, then low half
    assign mop  = (phase_reg == MP_HIGH) ? x_reg[31:16] : x_reg[15:0];
    assign pmul = 64'(mag_reg) * 64'(mop);

    // join partial products with clamping at 2^47
    always_comb begin
        tot_raw = 65'({ph_reg[31:0], 16'b0}) + 65'(p_reg);
        if (ph_reg[63:32] != '0 || tot_raw > 65'h0_0000_8000_0000_0000) begin
            tot = 48'h8000_0000_0000;
        end else begin
            tot = tot_raw[47:0];
        end
        tot_neg = -{1'b0, tot};
        if (neg_reg)                     res_calc = tot_neg[47:0];
        else if (tot > 48'(MAX48))       res_calc = MAX48;
        else                             res_calc = tot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MP_JOIN);
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == MP_IDLE && start) begin
            neg_reg <= a[47];
            mag_reg <= a[47] ? 48'(-a) : 48'(a);
            x_reg   <= x;
        end
        if (phase_reg == MP_HIGH) p_reg <= pmul;
        if (phase_reg == MP_LOW) begin
            ph_reg <= p_reg;
            p_reg  <= pmul;
        end
        if (phase_reg == MP_JOIN) res_reg <= res_calc;
    end

    assign done = done_reg;
    assign prod = res_reg;

endmodule

`default_nettype wire

### design/optimal_pla_segmenter_unit.sv
// ----------------------------------------------------------------------------
// optimal_pla_segmenter_unit
// Grows piecewise-linear segments under an error bound and reports each
// closed segment with its upper and lower bounding lines.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. A first sample of a segment only
// seeds both lists; the second makes two slope divisions and two offset
// products. Any later sample is tested against both lines by two
// products; if it lies in the band, it then takes one division for each
// support point scanned (the upper list when the upper line tightens,
// the lower list when the lower one does) and one product per scanned
// list for the new offset, then the room check, the drop of points from
// the front of the lists, and the append. A division with equal times
// returns zero without stepping. The shared slope divider retires one
// quotient bit per cycle over 49 bits, and the support chains present the
// next point at their head after each division. A closed segment waits
// in an output register while the next samples are accepted; a second
// closed segment stalls the input until the first is taken. error_bound
// may be written whenever the block is idle; cfg_ready is high only then.
// ----------------------------------------------------------------------------
`default_nettype none

`include "optimal_pla_segmenter_unit_macros.svh"

module optimal_pla_segmenter_unit
    import opseg_pkg::*;
#(
    parameter int HULL_DEPTH = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // cfg_data: error_bound
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [30:0]  cfg_data,
    // s_tdata: sample_time[31:0], sample_value[63:32]
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,
    // m_tdata: seg_start[31:0], seg_end[63:32], upper_slope[111:64],
    // upper_offset[159:112], lower_slope[207:160], lower_offset[255:208]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata,
    // m_tuser: closed_by_limit[0]
    output logic [0:0]        m_tuser
);

    localparam int IDX_W = (HULL_DEPTH > 1) ? $clog2(HULL_DEPTH) : 1;
    localparam int CNT_W = $clog2(HULL_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HULL_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_W = (CNT_W+1)'(HULL_DEPTH);

    // control registers
    state_t                 state_reg, state_next;
    logic [30:0]            err_reg, err_next;
    logic                   seg_active_reg, seg_active_next;
    logic                   lines_valid_reg, lines_valid_next;
    logic [CNT_W-1:0]       ucnt_reg, ucnt_next;
    logic [CNT_W-1:0]       lcnt_reg, lcnt_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic                   side_reg, side_next;
    logic                   upd_u_reg, upd_u_next;
    logic                   upd_l_reg, upd_l_next;
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            seg_start_reg, seg_start_next;
    logic signed [47:0]     u_slope_reg, u_slope_next;
    logic signed [47:0]     u_off_reg, u_off_next;
    logic signed [47:0]     l_slope_reg, l_slope_next;
    logic signed [47:0]     l_off_reg, l_off_next;

    // payload registers
    logic [31:0]            t_reg, t_next;
    logic signed [31:0]     hi_reg, hi_next;
    logic signed [31:0]     lo_reg, lo_next;
    logic signed [47:0]     uv_reg, uv_next;
    logic signed [47:0]     lv_reg, lv_next;
    logic signed [47:0]     best_reg, best_next;
    logic signed [47:0]     nu_slope_reg, nu_slope_next;
    logic signed [47:0]     nu_off_reg, nu_off_next;
    logic signed [47:0]     nl_slope_reg, nl_slope_next;
    logic signed [47:0]     nl_off_reg, nl_off_next;
    logic [IDX_W-1:0]       ui_reg, ui_next;
    logic [IDX_W-1:0]       li_reg, li_next;
    logic                   lim_reg, lim_next;
    logic [255:0]           out_data_reg, out_data_next;
    logic                   out_user_reg, out_user_next;

    // chain controls
    chain_op_t              u_op, l_op;
    logic [IDX_W-1:0]       u_sel, l_sel;
    logic [63:0]            u_din, l_din;
    logic [63:0]            u_head, l_head;

    // arithmetic units
    logic                   div_start, div_done;
    logic signed [32:0]     div_dy;
    logic [31:0]            div_dt;
    logic signed [47:0]     div_q;
    logic                   mul_start, mul_done;
    logic signed [47:0]     mul_a;
    logic signed [47:0]     mul_p;

    // working values
    logic signed [31:0]     in_val;
    logic signed [31:0]     in_hi, in_lo;
    logic [63:0]            head_sel;
    logic signed [31:0]     y_tar;
    logic [CNT_W-1:0]       cnt_sel;
    logic signed [47:0]     off_calc;
    logic signed [47:0]     val_calc;
    logic                   better;
    logic [CNT_W:0]         new_u, new_l;
    logic                   out_free;

    // band around the incoming sample
    assign in_val = s_tdata[63:32];
    assign in_hi  = sat32(34'(in_val) + 34'(err_reg));
    assign in_lo  = sat32(34'(in_val) - 34'(err_reg));

    // operands for the current side (upper or lower)
    assign head_sel = side_reg ? l_head : u_head;
    assign y_tar    = side_reg ? lo_reg : hi_reg;
    assign cnt_sel  = side_reg ? lcnt_reg : ucnt_reg;
    assign div_dy   = 33'(y_tar) - 33'($signed(head_sel[31:0]));
    assign div_dt   = t_reg - head_sel[63:32];
    assign off_calc = sat48(49'(y_tar) - 49'(mul_p));
    assign val_calc = sat48(49'(mul_p) + 49'(side_reg ? l_off_reg : u_off_reg));
    assign better   = side_reg ? (div_q > best_reg) : (div_q < best_reg);
    assign new_u    = {1'b0, ucnt_reg} - (CNT_W+1)'(ui_reg) + (CNT_W+1)'(upd_l_reg);
    assign new_l    = {1'b0, lcnt_reg} - (CNT_W+1)'(li_reg) + (CNT_W+1)'(upd_u_reg);
    assign out_free = !m_valid_reg || m_tready;

    // sequencer: next state and datapath updates
    always_comb begin
        state_next       = state_reg;
        err_next         = err_reg;
        seg_active_next  = seg_active_reg;
        lines_valid_next = lines_valid_reg;
        ucnt_next        = ucnt_reg;
        lcnt_next        = lcnt_reg;
        k_next           = k_reg;
        side_next        = side_reg;
        upd_u_next       = upd_u_reg;
        upd_l_next       = upd_l_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        seg_start_next   = seg_start_reg;
        u_slope_next     = u_slope_reg;
        u_off_next       = u_off_reg;
        l_slope_next     = l_slope_reg;
        l_off_next       = l_off_reg;
        t_next           = t_reg;
        hi_next          = hi_reg;
        lo_next          = lo_reg;
        uv_next          = uv_reg;
        lv_next          = lv_reg;
        best_next        = best_reg;
        nu_slope_next    = nu_slope_reg;
        nu_off_next      = nu_off_reg;
        nl_slope_next    = nl_slope_reg;
        nl_off_next      = nl_off_reg;
        ui_next          = ui_reg;
        li_next          = li_reg;
        lim_next         = lim_reg;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        u_op             = CH_HOLD;
        l_op             = CH_HOLD;
        u_sel            = '0;
        l_sel            = '0;
        u_din            = {t_reg, lo_reg};
        l_din            = {t_reg, hi_reg};
        div_start        = 1'b0;
        mul_start        = 1'b0;
        mul_a            = best_reg;

        if (cfg_valid && cfg_ready) err_next = cfg_data;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    t_next    = s_tdata[31:0];
                    hi_next   = in_hi;
                    lo_next   = in_lo;
                    side_next = 1'b0;
                    if (!seg_active_reg) begin
                        // first sample seeds both lists
                        u_op             = CH_LOAD;
                        l_op             = CH_LOAD;
                        u_din            = {s_tdata[31:0], in_lo};
                        l_din            = {s_tdata[31:0], in_hi};
                        ucnt_next        = CNT_W'(1);
                        lcnt_next        = CNT_W'(1);
                        seg_start_next   = s_tdata[31:0];
                        seg_active_next  = 1'b1;
                        lines_valid_next = 1'b0;
                    end else if (!lines_valid_reg) begin
                        state_next = ST_INIT_DIV;
                    end else begin
                        state_next = ST_EVAL_MUL;
                    end
                end
            end

            // second sample: lines through the first point
            ST_INIT_DIV: begin
                div_start  = 1'b1;
                state_next = ST_INIT_DIVW;
            end
            ST_INIT_DIVW: begin
                if (div_done) begin
                    best_next  = div_q;
                    state_next = ST_INIT_MUL;
                end
            end
            ST_INIT_MUL: begin
                mul_start  = 1'b1;
                state_next = ST_INIT_MULW;
            end
            ST_INIT_MULW: begin
                if (mul_done) begin
                    if (!side_reg) begin
                        u_slope_next = best_reg;
                        u_off_next   = off_calc;
                        side_next    = 1'b1;
                        state_next   = ST_INIT_DIV;
                    end else begin
                        l_slope_next     = best_reg;
                        l_off_next       = off_calc;
                        u_op             = CH_LOAD;
                        l_op             = CH_LOAD;
                        u_sel            = IDX_W'(1);
                        l_sel            = IDX_W'(1);
                        ucnt_next        = CNT_W'(2);
                        lcnt_next        = CNT_W'(2);
                        lines_valid_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
            end

            // lines evaluated at the sample time
            ST_EVAL_MUL: begin
                mul_start  = 1'b1;
                mul_a      = side_reg ? l_slope_reg : u_slope_reg;
                state_next = ST_EVAL_MULW;
            end
            ST_EVAL_MULW: begin
                mul_a = side_reg ? l_slope_reg : u_slope_reg;
                if (mul_done) begin
                    if (!side_reg) begin
                        uv_next    = val_calc;
                        side_next  = 1'b1;
                        state_next = ST_EVAL_MUL;
                    end else begin
                        lv_next    = val_calc;
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE: begin
                ui_next    = '0;
                li_next    = '0;
                upd_u_next = 48'(hi_reg) < uv_reg;
                upd_l_next = 48'(lo_reg) > lv_reg;
                k_next     = '0;
                if (lv_reg > 48'(hi_reg) || 48'(lo_reg) > uv_reg) begin
                    lim_next   = 1'b0;
                    state_next = ST_EMIT;
                end else if (48'(hi_reg) < uv_reg) begin
                    side_next  = 1'b0;
                    state_next = ST_SCAN_DIV;
                end else if (48'(lo_reg) > lv_reg) begin
                    side_next  = 1'b1;
                    state_next = ST_SCAN_DIV;
                end else begin
                    state_next = ST_CHECK;
                end
            end

            // slope scan, one support point per pass, chain rotates
            ST_SCAN_DIV: begin
                div_start  = 1'b1;
                state_next = ST_SCAN_DIVW;
            end
            ST_SCAN_DIVW: begin
                if (div_done) begin
                    if (k_reg == '0 || better) begin
                        best_next = div_q;
                        if (side_reg) li_next = k_reg[IDX_W-1:0];
                        else          ui_next = k_reg[IDX_W-1:0];
                    end
                    if (side_reg) begin
                        l_op  = CH_ROTATE;
                        l_sel = IDX_W'(cnt_sel - CNT_W'(1));
                    end else begin
                        u_op  = CH_ROTATE;
                        u_sel = IDX_W'(cnt_sel - CNT_W'(1));
                    end
                    k_next = k_reg + CNT_W'(1);
                    if (k_reg + CNT_W'(1) == cnt_sel) state_next = ST_SCAN_MUL;
                    else                              state_next = ST_SCAN_DIV;
                end
            end
            ST_SCAN_MUL: begin
                mul_start  = 1'b1;
                state_next = ST_SCAN_MULW;
            end
            ST_SCAN_MULW: begin
                if (mul_done) begin
                    k_next = '0;
                    if (!side_reg) begin
                        nu_slope_next = best_reg;
                        nu_off_next   = off_calc;
                        if (upd_l_reg) begin
                            side_next  = 1'b1;
                            state_next = ST_SCAN_DIV;
                        end else begin
                            state_next = ST_CHECK;
                        end
                    end else begin
                        nl_slope_next = best_reg;
                        nl_off_next   = off_calc;
                        state_next    = ST_CHECK;
                    end
                end
            end

            // room check, then commit the tightened lines
            ST_CHECK: begin
                if (new_u > DEPTH_W || new_l > DEPTH_W) begin
                    lim_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    if (upd_u_reg) begin
                        u_slope_next = nu_slope_reg;
                        u_off_next   = nu_off_reg;
                    end
                    if (upd_l_reg) begin
                        l_slope_next = nl_slope_reg;
                        l_off_next   = nl_off_reg;
                    end
                    state_next = ST_DROP;
                end
            end

            // drop earlier points one a cycle
            ST_DROP: begin
                if (ui_reg != '0) begin
                    u_op      = CH_SHIFT;
                    ui_next   = ui_reg - IDX_W'(1);
                    ucnt_next = ucnt_reg - CNT_W'(1);
                end
                if (li_reg != '0) begin
                    l_op      = CH_SHIFT;
                    li_next   = li_reg - IDX_W'(1);
                    lcnt_next = lcnt_reg - CNT_W'(1);
                end
                if (ui_reg == '0 && li_reg == '0) state_next = ST_APPEND;
            end

            ST_APPEND: begin
                if (upd_l_reg) begin
                    u_op      = CH_LOAD;
                    u_sel     = ucnt_reg[IDX_W-1:0];
                    ucnt_next = ucnt_reg + CNT_W'(1);
                end
                if (upd_u_reg) begin
                    l_op      = CH_LOAD;
                    l_sel     = lcnt_reg[IDX_W-1:0];
                    lcnt_next = lcnt_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end

            // report the closed segment and restart at this sample
            ST_EMIT: begin
                if (out_free) begin
                    out_data_next    = {l_off_reg, l_slope_reg, u_off_reg, u_slope_reg,
                                        t_reg - 32'd1, seg_start_reg};
                    out_user_next    = lim_reg;
                    m_valid_next     = 1'b1;
                    u_op             = CH_LOAD;
                    l_op             = CH_LOAD;
                    ucnt_next        = CNT_W'(1);
                    lcnt_next        = CNT_W'(1);
                    seg_start_next   = t_reg;
                    lines_valid_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            err_reg         <= ERR_BOUND_RESET;
            seg_active_reg  <= 1'b0;
            lines_valid_reg <= 1'b0;
            ucnt_reg        <= '0;
            lcnt_reg        <= '0;
            k_reg           <= '0;
            side_reg        <= 1'b0;
            upd_u_reg       <= 1'b0;
            upd_l_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
            seg_start_reg   <= '0;
            u_slope_reg     <= '0;
            u_off_reg       <= '0;
            l_slope_reg     <= '0;
            l_off_reg       <= '0;
        end else begin
            state_reg       <= state_next;
            err_reg         <= err_next;
            seg_active_reg  <= seg_active_next;
            lines_valid_reg <= lines_valid_next;
            ucnt_reg        <= ucnt_next;
            lcnt_reg        <= lcnt_next;
            k_reg           <= k_next;
            side_reg        <= side_next;
            upd_u_reg       <= upd_u_next;
            upd_l_reg       <= upd_l_next;
            m_valid_reg     <= m_valid_next;
            seg_start_reg   <= seg_start_next;
            u_slope_reg     <= u_slope_next;
            u_off_reg       <= u_off_next;
            l_slope_reg     <= l_slope_next;
            l_off_reg       <= l_off_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        t_reg        <= t_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        uv_reg       <= uv_next;
        lv_reg       <= lv_next;
        best_reg     <= best_next;
        nu_slope_reg <= nu_slope_next;
        nu_off_reg   <= nu_off_next;
        nl_slope_reg <= nl_slope_next;
        nl_off_reg   <= nl_off_next;
        ui_reg       <= ui_next;
        li_reg       <= li_next;
        lim_reg      <= lim_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // support chains
    opseg_chain #(
        .DEPTH (HULL_DEPTH),
        .IDX_W (IDX_W)
    ) u_upper_chain (
        .aclk (aclk),
        .op   (u_op),
        .sel  (u_sel),
        .din  (u_din),
        .head (u_head)
    );

    opseg_chain #(
        .DEPTH (HULL_DEPTH),
        .IDX_W (IDX_W)
    ) u_lower_chain (
        .aclk (aclk),
        .op   (l_op),
        .sel  (l_sel),
        .din  (l_din),
        .head (l_head)
    );

    // shared slope divider and product unit
    opseg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dy      (div_dy),
        .dt      (div_dt),
        .done    (div_done),
        .quot    (div_q)
    );

    opseg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .x       (t_reg),
        .done    (mul_done),
        .prod    (mul_p)
    );

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // checks
    `OPS_ASSERT_IMP(a_cnt_bound, 1'b1, (ucnt_reg <= DEPTH_C) && (lcnt_reg <= DEPTH_C), "support count above depth")
    `OPS_ASSERT_IMP(a_lines_need_points, lines_valid_reg, seg_active_reg && ucnt_reg != '0 && lcnt_reg != '0, "lines valid without support points")
    `OPS_ASSERT_IMP(a_div_when_waiting, div_done, state_reg == ST_INIT_DIVW || state_reg == ST_SCAN_DIVW, "quotient arrived outside a wait state")
    `OPS_ASSERT_NXT(a_emit_result, state_reg == ST_EMIT && out_free, m_valid_reg && !lines_valid_reg && ucnt_reg == CNT_W'(1), "closed segment not posted")

endmodule

`default_nettype wire

### test/tb_optimal_pla_segmenter_unit.sv
// ----------------------------------------------------------------------------
// tb_optimal_pla_segmenter_unit
// Self-checking bench for the PLA segmenter: an in-bench segment predictor
// tracks both support lists and bounding lines, and every closed-segment
// request from the block is compared field by field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_optimal_pla_segmenter_unit
    import opseg_pkg::*;
;

    localparam int DEPTH = 64;
    localparam int SETTLE_CYCLES = 8000;
    localparam longint P48 = 64'sd140737488355327;
    localparam longint N48 = -64'sd140737488355328;

    typedef struct {
        bit [31:0] first_t;
        bit [31:0] last_t;
        bit [47:0] up_slope;
        bit [47:0] up_off;
        bit [47:0] lo_slope;
        bit [47:0] lo_off;
        bit        by_limit;
    } segment_rec_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [30:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;     // sample_time[31:0], sample_value[63:32]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;          // seg_start, seg_end, upper/lower slope+offset
    logic [0:0]   m_tuser;          // closed_by_limit[0]

    optimal_pla_segmenter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // predictor state
    bit [30:0]    bound;
    bit [31:0]    up_t[DEPTH];
    longint       up_v[DEPTH];
    bit [31:0]    lo_t[DEPTH];
    longint       lo_v[DEPTH];
    int           up_cnt, lo_cnt;
    longint       ul_slope, ul_off, ll_slope, ll_off;
    bit [31:0]    seg_first;
    bit           seg_open, lines_set;
    segment_rec_t pending_segments[$];

    int err_count = 0;
    int samples_sent = 0;
    int segments_seen = 0;
    int limit_closes = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;

    function automatic longint clamp48(longint x);
        if (x > P48) return P48;
        if (x < N48) return N48;
        return x;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // slope * time, saturated to 48 bits
    function automatic longint scale_sat(longint a, bit [31:0] x);
        bit neg;
        longint unsigned mag, ph, tot;
        neg = a < 0;
        mag = neg ? longint'(-a) : longint'(a);
        ph = mag * longint'(x[31:16]);
        if (ph >= 64'd4294967296) tot = 64'd1 << 47;
        else tot = (ph << 16) + mag * longint'(x[15:0]);
        if (tot > (64'd1 << 47)) tot = 64'd1 << 47;
        if (neg) return -longint'(tot);
        return (tot > P48) ? P48 : longint'(tot);
    endfunction

    function automatic void line_through(input bit [31:0] ta, input longint ya,
                                         input bit [31:0] tb, input longint yb,
                                         output longint slope, output longint off);
        bit [31:0] dt;
        dt = tb - ta;
        slope = (dt == 0) ? 0 : clamp48(((yb - ya) * 65536) / longint'(dt));
        off = clamp48(yb - scale_sat(slope, tb));
    endfunction

    function automatic longint line_value(longint slope, longint off, bit [31:0] t);
        return clamp48(scale_sat(slope, t) + off);
    endfunction

    function automatic void open_segment(bit [31:0] t, longint hi, longint lo);
        seg_first = t;
        up_t[0] = t; up_v[0] = lo;
        lo_t[0] = t; lo_v[0] = hi;
        up_cnt = 1; lo_cnt = 1;
        lines_set = 0;
        seg_open = 1;
    endfunction

    function automatic void close_segment(bit [31:0] t, bit lim);
        segment_rec_t r;
        r.first_t = seg_first;
        r.last_t = t - 1;
        r.up_slope = ul_slope[47:0];
        r.up_off = ul_off[47:0];
        r.lo_slope = ll_slope[47:0];
        r.lo_off = ll_off[47:0];
        r.by_limit = lim;
        pending_segments = {pending_segments, r};
    endfunction

    // tightest line from any support point to (t,y); earliest wins ties
    function automatic int best_pivot(bit is_upper, bit [31:0] t, longint y,
                                      output longint bs, output longint bo);
        longint cs, co;
        int idx, n;
        idx = 0;
        n = is_upper ? up_cnt : lo_cnt;
        for (int i = 0; i < n; i++) begin
            if (is_upper) line_through(up_t[i], up_v[i], t, y, cs, co);
            else line_through(lo_t[i], lo_v[i], t, y, cs, co);
            if (i == 0 || (is_upper ? cs < bs : cs > bs)) begin
                bs = cs; bo = co; idx = i;
            end
        end
        return idx;
    endfunction

    function automatic void predict_sample(bit [31:0] t, bit [31:0] raw);
        longint v, hi, lo, uv, lv, nus, nuo, nls, nlo;
        bit tight_u, tight_l;
        int ui, li;
        ui = 0; li = 0;
        v = longint'($signed(raw));
        hi = clamp32(v + longint'(bound));
        lo = clamp32(v - longint'(bound));
        if (!seg_open) begin
            open_segment(t, hi, lo);
            return;
        end
        if (!lines_set) begin
            line_through(up_t[0], up_v[0], t, hi, ul_slope, ul_off);
            line_through(lo_t[0], lo_v[0], t, lo, ll_slope, ll_off);
            up_t[1] = t; up_v[1] = lo;
            lo_t[1] = t; lo_v[1] = hi;
            up_cnt = 2; lo_cnt = 2;
            lines_set = 1;
            return;
        end
        uv = line_value(ul_slope, ul_off, t);
        lv = line_value(ll_slope, ll_off, t);
        // sample falls outside the band
        if (lv > hi || lo > uv) begin
            close_segment(t, 1'b0);
            open_segment(t, hi, lo);
            return;
        end
        tight_u = hi < uv;
        tight_l = lo > lv;
        if (tight_u) ui = best_pivot(1'b1, t, hi, nus, nuo);
        if (tight_l) li = best_pivot(1'b0, t, lo, nls, nlo);
        // support list would overflow
        if (up_cnt - ui + tight_l > DEPTH || lo_cnt - li + tight_u > DEPTH) begin
            close_segment(t, 1'b1);
            open_segment(t, hi, lo);
            return;
        end
        if (tight_u) begin
            ul_slope = nus; ul_off = nuo;
            for (int i = 0; i < up_cnt - ui; i++) begin
                up_t[i] = up_t[i + ui]; up_v[i] = up_v[i + ui];
            end
            up_cnt -= ui;
        end
        if (tight_l) begin
            ll_slope = nls; ll_off = nlo;
            for (int i = 0; i < lo_cnt - li; i++) begin
                lo_t[i] = lo_t[i + li]; lo_v[i] = lo_v[i + li];
            end
            lo_cnt -= li;
        end
        if (tight_u) begin
            lo_t[lo_cnt] = t; lo_v[lo_cnt] = hi; lo_cnt++;
        end
        if (tight_l) begin
            up_t[up_cnt] = t; up_v[up_cnt] = lo; up_cnt++;
        end
    endfunction

    task automatic report_mismatch(input string what, input bit [47:0] got,
                                   input bit [47:0] want);
        $display("ERROR segment %0d %s: got %h, expected %h", segments_seen, what, got, want);
        err_count++;
    endtask

    // send one sample request; predictor runs on acceptance
    task automatic send_sample(input bit [31:0] t, input bit [31:0] v);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {v, t};
        do @(posedge aclk); while (!s_tready);
        predict_sample(t, v);
        samples_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for all results plus the worst scan time before touching config
    task automatic drain();
        stop_sending();
        while (pending_segments.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bound(input bit [30:0] val);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        bound = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // result checking and receiver idling
    always @(posedge aclk) begin
        segment_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_segments.size() == 0) begin
                report_mismatch("unexpected segment, start", m_tdata[31:0], '0);
            end else begin
                want = pending_segments.pop_front();
                if (m_tdata[31:0] != want.first_t)
                    report_mismatch("seg_start", m_tdata[31:0], want.first_t);
                if (m_tdata[63:32] != want.last_t)
                    report_mismatch("seg_end", m_tdata[63:32], want.last_t);
                if (m_tdata[111:64] != want.up_slope)
                    report_mismatch("upper_slope", m_tdata[111:64], want.up_slope);
                if (m_tdata[159:112] != want.up_off)
                    report_mismatch("upper_offset", m_tdata[159:112], want.up_off);
                if (m_tdata[207:160] != want.lo_slope)
                    report_mismatch("lower_slope", m_tdata[207:160], want.lo_slope);
                if (m_tdata[255:208] != want.lo_off)
                    report_mismatch("lower_offset", m_tdata[255:208], want.lo_off);
                if (m_tuser[0] != want.by_limit)
                    report_mismatch("closed_by_limit", m_tuser[0], want.by_limit);
                if (want.by_limit) limit_closes++;
            end
            segments_seen++;
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // field extremes, wrap of time, equal times, outside-band breaks
    task automatic test_directed_extremes();
        send_sample(32'd0, 32'h0000_0000);
        send_sample(32'd1, 32'h7FFF_FFFF);
        send_sample(32'd2, 32'h8000_0000);
        send_sample(32'd3, 32'h8000_0000);
        send_sample(32'd3, 32'h8000_0001);
        send_sample(32'd4, 32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFE, 32'h0001_0000);
        send_sample(32'hFFFF_FFFF, 32'h0002_0000);
        send_sample(32'h0000_0000, 32'h0003_0000);
        send_sample(32'h0000_0001, 32'h0004_0000);
        send_sample(32'h0000_0002, 32'hFFFF_0000);
        send_sample(32'h8000_0000, 32'h0000_0000);
        send_sample(32'h8000_0001, 32'h5555_5555);
        send_sample(32'h8000_0002, 32'hAAAA_AAAA);
        send_sample(32'h8000_0003, 32'h0000_8000);
        send_sample(32'h8000_0004, 32'h0000_8000);
        send_sample(32'h8000_0005, 32'h0000_7000);
        send_sample(32'h8000_0006, 32'h0000_9000);
        send_sample(32'h8000_0007, 32'h7FFF_0000);
        drain();
    endtask

    // zero and maximum bound, a bound that saturates both band edges
    task automatic test_bound_extremes();
        bit [31:0] t;
        write_bound(31'd0);
        t = 32'd100;
        for (int i = 0; i < 8; i++) begin
            send_sample(t, (i < 5) ? 32'(i * 65536) : 32'h0010_0000);
            t++;
        end
        drain();
        write_bound(31'h7FFF_FFFF);
        for (int i = 0; i < 6; i++) begin
            send_sample(t, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
            t++;
        end
        drain();
    endtask

    // damped oscillation keeps tightening both lines, growing the lists
    task automatic test_full_list();
        bit [31:0] t;
        longint amp;
        write_bound(31'd65536);
        t = 32'd5000;
        for (int k = 0; k < 180; k++) begin
            amp = 64'sd60000 - longint'(k) * 300;
            if (amp < 0) amp = 0;
            send_sample(t, 32'((k % 2) ? amp : -amp));
            t++;
        end
        drain();
    endtask

    // mostly trends with noise inside the band, some breaks and junk samples
    task automatic test_random_segments(input int n, input bit [30:0] eb);
        bit [31:0] t, v;
        longint base, slope, noise, y;
        int len, sent;
        write_bound(eb);
        t = $urandom;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                t = $urandom;
                send_sample(t, $urandom);
                t++;
                sent++;
            end else begin
                base = longint'($signed(32'($urandom)) >>> $urandom_range(0, 12));
                slope = longint'($signed(32'($urandom)) >>> $urandom_range(8, 24));
                len = ($urandom_range(3) == 0) ? $urandom_range(40, 90) : $urandom_range(2, 30);
                for (int i = 0; i < len && sent < n; i++) begin
                    noise = (eb == 0) ? 0 : longint'($urandom_range(0, eb)) - longint'(eb / 2);
                    y = clamp32(base + slope * i + noise);
                    v = 32'(y);
                    send_sample(t, v);
                    t++;
                    sent++;
                end
            end
        end
        drain();
    endtask

    // receiver stops for a long stretch while breaking samples keep coming
    task automatic test_backpressure();
        bit [31:0] t;
        write_bound(31'd256);
        recv_idle_pct = 0;
        send_idle_pct = 0;
        hold_off = 30000;
        t = 32'd9000;
        for (int i = 0; i < 40; i++) begin
            send_sample(t, 32'((i % 3) * 32'h0100_0000));
            t++;
        end
        drain();
    endtask

    initial begin
        bound = ERR_BOUND_RESET;
        up_cnt = 0; lo_cnt = 0;
        ul_slope = 0; ul_off = 0; ll_slope = 0; ll_off = 0;
        seg_first = 0; seg_open = 0; lines_set = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 21; recv_idle_pct = 75;
        test_directed_extremes();
        test_bound_extremes();
        test_full_list();
        test_random_segments(180, 31'd65536);

        send_idle_pct = 75; recv_idle_pct = 21;
        test_random_segments(180, 31'd4096);

        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_segments(180, 31'($urandom_range(0, 31'h7FFF_FFFF) >> $urandom_range(0, 20)));
        test_backpressure();

        $display("Run covered %0d samples and %0d closed segments (%0d on full lists),",
                 samples_sent, segments_seen, limit_closes);
        $display("across zero, maximum and random error bounds with idle and stall phases.");
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/opseg_pkg.sv
design/opseg_cell.sv
design/opseg_chain.sv
design/opseg_div.sv
design/opseg_mul.sv
design/optimal_pla_segmenter_unit.sv
test/tb_optimal_pla_segmenter_unit.sv
